FILE: src/spq_pkg.sv
// shared types and constants for the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

	// number of entries held in the cell chain
	localparam int CAPACITY = 16;
	// entry count width, wide enough to hold CAPACITY itself
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// width of the occupancy field on the result word
	localparam int OCC_W = 5;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// one stored entry
	typedef struct packed {
		logic signed [31:0] data;
		logic [15:0]        prio;
	} entry_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic ins;
		logic rem;
	} ctrl_t;

endpackage

FILE: src/spq_cell.sv
// one cell of the sorted chain: holds a single entry and shifts with its neighbors
`timescale 1ns / 1ps

module spq_cell (
	input  logic           clk,
	input  spq_pkg::ctrl_t ctrl,
	input  logic           occupied,
	input  spq_pkg::entry_t new_entry,
	input  spq_pkg::entry_t left_entry,
	input  spq_pkg::entry_t right_entry,
	input  logic           left_ahead,
	output logic           ahead,
	output spq_pkg::entry_t entry
);

	spq_pkg::entry_t entry_q;

	// new entry belongs ahead of this cell's entry (ties stay behind)
	assign ahead = !occupied || (entry_q.prio > new_entry.prio);
	assign entry = entry_q;

	// insert: take the new entry at the boundary, shift right behind it
	// remove: shift everything one place toward the head
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_ahead) begin
				entry_q <= left_entry;
			end else if (ahead) begin
				entry_q <= new_entry;
			end
		end else if (ctrl.rem) begin
			entry_q <= right_entry;
		end
	end

endmodule

FILE: src/sorted_priority_queue.sv
// sorted priority queue top level: cell chain, entry count and result register
//
//  channel | direction | handshake          | fields
//  input   | in        | in_valid/in_stall   | command, value, priority_req
//  result  | out       | out_valid/out_stall | status, removed_value, removed_priority,
//          |           |                     | occupancy
//
// one word accepted per cycle unless stalled; its result appears in the result
// register on the next cycle; every cell compares its own priority with the new one in
// parallel, so an insert or a remove needs no search along the chain at any occupancy
// reset empties the queue at once (entry count to zero); no clearing pass
// the input stalls only while a finished result is held by a stalled output
`timescale 1ns / 1ps

module sorted_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic signed [31:0]  value,
	input  logic [15:0]         priority_req,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          status,
	output logic signed [31:0]  removed_value,
	output logic [15:0]         removed_priority,
	output logic [4:0]          occupancy
);

	localparam int N = spq_pkg::CAPACITY;

	logic [spq_pkg::CNT_W-1:0] count_q;
	logic [spq_pkg::CNT_W-1:0] count_d;
	logic                      out_valid_q;
	spq_pkg::status_t          status_q;
	spq_pkg::status_t          status_d;
	logic signed [31:0]        removed_value_q;
	logic [15:0]               removed_priority_q;
	logic [spq_pkg::OCC_W-1:0] occupancy_q;
	logic [spq_pkg::CNT_W+spq_pkg::OCC_W-1:0] count_ext;

	logic            in_fire;
	logic            is_full;
	logic            is_empty;
	spq_pkg::ctrl_t  ctrl;
	spq_pkg::entry_t new_entry;
	spq_pkg::entry_t cell_entry [N];
	logic [N-1:0]    cell_ahead;
	logic [N-1:0]    cell_occupied;
	logic [N-2:0]    order_ok;

	// handshake: input moves whenever the result register can be refilled
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;

	assign is_full  = (count_q == spq_pkg::CNT_W'(N));
	assign is_empty = (count_q == '0);

	assign ctrl.ins = in_fire && (command == spq_pkg::CMD_INSERT) && !is_full;
	assign ctrl.rem = in_fire && (command == spq_pkg::CMD_REMOVE) && !is_empty;

	assign new_entry.data = value;
	assign new_entry.prio = priority_req;

	// cell chain
	for (genvar i = 0; i < N; i++) begin : g_cell
		assign cell_occupied[i] = (spq_pkg::CNT_W'(i) < count_q);

		spq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occupied    (cell_occupied[i]),
			.new_entry   (new_entry),
			.left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
			.right_entry (cell_entry[(i == N - 1) ? i : i + 1]),
			.left_ahead  ((i == 0) ? 1'b0 : cell_ahead[(i == 0) ? 0 : i - 1]),
			.ahead       (cell_ahead[i]),
			.entry       (cell_entry[i])
		);
	end

	// adjacent occupied cells stay in ascending priority order
	for (genvar i = 0; i < N - 1; i++) begin : g_order
		assign order_ok[i] = !cell_occupied[i + 1] ||
			(cell_entry[i].prio <= cell_entry[i + 1].prio);
	end

	// next count and status
	always_comb begin
		count_d = count_q;
		if (command == spq_pkg::CMD_INSERT) begin
			status_d = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_INSERTED;
		end else begin
			status_d = is_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_REMOVED;
		end
		if (ctrl.ins) begin
			count_d = count_q + 1'b1;
		end else if (ctrl.rem) begin
			count_d = count_q - 1'b1;
		end
	end

	// occupancy is the count masked to the field width
	assign count_ext = {{spq_pkg::OCC_W{1'b0}}, count_d};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			status_q           <= status_d;
			removed_value_q    <= ctrl.rem ? cell_entry[0].data : 32'sd0;
			removed_priority_q <= ctrl.rem ? cell_entry[0].prio : 16'd0;
			occupancy_q        <= count_ext[spq_pkg::OCC_W-1:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign removed_value    = removed_value_q;
	assign removed_priority = removed_priority_q;
	assign occupancy        = occupancy_q;

	// count never passes the capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(N))
		else $error("entry count beyond capacity");

	// held entries stay sorted
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		&order_ok)
		else $error("cell chain out of priority order");

	// a successful remove lowers the count by one
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rem |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not decrement count");

	// only a remove carries a data word out
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != spq_pkg::ST_REMOVED) |->
			(removed_value == 32'sd0) && (removed_priority == 16'd0))
		else $error("nonzero removed fields without a remove");

endmodule

FILE: verif/sorted_queue_checker.sv
// checker for the sorted priority queue: predicts each result word and compares it field by field
`timescale 1ns / 1ps

module sorted_queue_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               command,
	input  logic signed [31:0] value,
	input  logic [15:0]        priority_req,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         status,
	input  logic signed [31:0] removed_value,
	input  logic [15:0]        removed_priority,
	input  logic [4:0]         occupancy,
	output int                 fail_count,
	output int                 pending
);

	// one predicted result word
	typedef struct {
		spq_pkg::status_t          st;
		logic signed [31:0]        val;
		logic [15:0]               pri;
		logic [spq_pkg::OCC_W-1:0] occ;
	} outcome_t;

	// shadow copy of the queue, most urgent entry at index 0
	spq_pkg::entry_t held [spq_pkg::CAPACITY];
	int              held_cnt;
	outcome_t        awaited_results [$];

	// apply one insert or remove to the shadow queue and return its result word
	function automatic outcome_t apply_queue_op(logic cmd, logic signed [31:0] val,
			logic [15:0] pri);
		outcome_t res;
		int       pos;
		res.val = '0;
		res.pri = '0;
		if (cmd == spq_pkg::CMD_INSERT) begin
			if (held_cnt >= spq_pkg::CAPACITY) begin
				res.st = spq_pkg::ST_FULL;
			end else begin
				// new entry goes behind every entry of equal priority
				pos = 0;
				while (pos < held_cnt && held[pos].prio <= pri)
					pos++;
				for (int i = held_cnt; i > pos; i--)
					held[i] = held[i - 1];
				held[pos].data = val;
				held[pos].prio = pri;
				held_cnt++;
				res.st = spq_pkg::ST_INSERTED;
			end
		end else if (held_cnt == 0) begin
			res.st = spq_pkg::ST_EMPTY;
		end else begin
			res.val = held[0].data;
			res.pri = held[0].prio;
			for (int i = 1; i < held_cnt; i++)
				held[i - 1] = held[i];
			held_cnt--;
			res.st = spq_pkg::ST_REMOVED;
		end
		res.occ = held_cnt[spq_pkg::OCC_W-1:0];
		return res;
	endfunction

	// report one field that differs, returns 1 on a mismatch
	function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// watch both channels; results are checked before the new word is predicted
	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		int       bad;
		if (!arst_n) begin
			held_cnt = 0;
			awaited_results.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			bad = 0;
			// result word leaves the block
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$error("result word with no word outstanding");
					bad++;
				end else begin
					want = awaited_results.pop_front();
					bad += field_mismatch("status", 32'(want.st), 32'(status));
					bad += field_mismatch("removed_value", want.val, removed_value);
					bad += field_mismatch("removed_priority", 32'(want.pri),
						32'(removed_priority));
					bad += field_mismatch("occupancy", 32'(want.occ), 32'(occupancy));
				end
			end
			// input word enters the block
			if (in_valid && !in_stall)
				awaited_results.push_back(apply_queue_op(command, value, priority_req));
			pending    <= awaited_results.size();
			fail_count <= fail_count + bad;
		end
	end

endmodule

FILE: verif/sorted_priority_queue_tb.sv
// testbench top for the sorted priority queue: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

	localparam int PHASE_LEN        = 50;
	localparam int NUM_PHASES       = 21;
	localparam int LONG_HOLD_CYCLES = 80;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               command;
	logic signed [31:0] value;
	logic [15:0]        priority_req;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic signed [31:0] removed_value;
	logic [15:0]        removed_priority;
	logic [4:0]         occupancy;
	int                 fail_count;
	int                 pending;

	// idling modes and long hold-off requests, set by the stimulus
	bit tx_burst;
	bit rx_free;
	int long_holds_asked;
	int long_holds_done;

	sorted_priority_queue DUT (.*);

	sorted_queue_checker u_check (.*);

	// clock
	always #2 clk = ~clk;

	// run limit
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// offer one word after a random gap (none in burst mode) and wait until it is taken
	task automatic send_word(input logic cmd, input logic signed [31:0] val,
			input logic [15:0] pri);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		value        <= val;
		priority_req <= pri;
		do @(posedge clk); while (in_stall);
	endtask

	// result side: random stall before each word unless free, long hold-off on request
	initial begin : receiver
		int hold;
		out_stall       = 1'b0;
		long_holds_done = 0;
		wait (arst_n);
		forever begin
			if (long_holds_done < long_holds_asked) begin
				hold = LONG_HOLD_CYCLES;
				long_holds_done++;
			end else begin
				hold = rx_free ? 0 : $urandom_range(0, 15);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int                 ins_pct;
		int                 pri_mode;
		logic               cmd;
		logic signed [31:0] val;
		logic [15:0]        pri;
		clk              = 1'b0;
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		command          = spq_pkg::CMD_INSERT;
		value            = '0;
		priority_req     = '0;
		tx_burst         = 1'b0;
		rx_free          = 1'b0;
		long_holds_asked = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// remove from an empty queue
		send_word(spq_pkg::CMD_REMOVE, 32'sh0, 16'h0000);
		// extremes and ties, filling the queue
		send_word(spq_pkg::CMD_INSERT, 32'sh7FFFFFFF, 16'h8000);
		send_word(spq_pkg::CMD_INSERT, 32'sh80000000, 16'hFFFF);
		send_word(spq_pkg::CMD_INSERT, 32'sh0, 16'h0000);
		send_word(spq_pkg::CMD_INSERT, -32'sd1, 16'h0000);
		send_word(spq_pkg::CMD_INSERT, 32'sh55555555, 16'hFFFF);
		send_word(spq_pkg::CMD_INSERT, 32'shAAAAAAAA, 16'h8000);
		for (int i = 0; i < 10; i++)
			send_word(spq_pkg::CMD_INSERT, 32'(i), 16'h00F0 - 16'(i));
		// insert into a full queue is dropped
		send_word(spq_pkg::CMD_INSERT, 32'sd12345, 16'h0000);
		repeat (4) send_word(spq_pkg::CMD_REMOVE, -32'sd1, 16'hFFFF);

		// random phases with varying insert mix, priority spread and idling
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case ($urandom_range(0, 2))
				0: ins_pct = 20;
				1: ins_pct = 50;
				default: ins_pct = 80;
			endcase
			pri_mode = $urandom_range(0, 2);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_free  = ($urandom_range(0, 3) == 0);
			// back-to-back words against a long result hold-off
			if (ph == 4 || ph == 14) begin
				tx_burst = 1'b1;
				rx_free  = 1'b0;
				ins_pct  = 80;
				long_holds_asked++;
			end
			for (int n = 0; n < PHASE_LEN; n++) begin
				cmd = ($urandom_range(1, 100) <= ins_pct) ? spq_pkg::CMD_INSERT :
					spq_pkg::CMD_REMOVE;
				case (pri_mode)
					0: pri = 16'($urandom_range(0, 3));
					1: pri = 16'($urandom);
					default: begin
						case ($urandom_range(0, 4))
							0: pri = 16'h0000;
							1: pri = 16'hFFFF;
							2: pri = 16'h7FFF;
							3: pri = 16'h8000;
							default: pri = 16'($urandom);
						endcase
					end
				endcase
				if ($urandom_range(0, 7) == 0) begin
					case ($urandom_range(0, 3))
						0: val = 32'sh7FFFFFFF;
						1: val = 32'sh80000000;
						2: val = -32'sd1;
						default: val = 32'sh0;
					endcase
				end else begin
					val = $urandom;
				end
				send_word(cmd, val, pri);
			end
		end
		in_valid <= 1'b0;

		// drain outstanding results, then let the bench settle before the verdict
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
